// ----- sv/srpd_pkg.sv -----
// Shared types and constants for the score reel pulse driver.
// No dependencies; used by srpd_reel and score_reel_pulse_driver_top.
package srpd_pkg;

	localparam int NUM_DISPLAYS      = 2;
	localparam int REELS_PER_DISPLAY = 5;
	localparam int HOME_ROUNDS       = 10;
	localparam int NUM_REELS         = NUM_DISPLAYS * REELS_PER_DISPLAY;

	localparam logic [3:0] DIGIT_MAX   = 4'd9;
	localparam logic [4:0] DIGIT_COUNT = 5'd10;
	localparam logic [7:0] QUEUE_MAX   = 8'hFF;

	// Item kinds
	localparam logic [1:0] OP_SET  = 2'd0;
	localparam logic [1:0] OP_TICK = 2'd1;
	localparam logic [1:0] OP_HOME = 2'd2;

	// Register indexes
	localparam logic [1:0] REG_PULSE_TICKS = 2'd0;
	localparam logic [1:0] REG_GAP_TICKS   = 2'd1;
	localparam logic [1:0] REG_HOME_PAUSE  = 2'd2;
	localparam logic [1:0] REG_UPDATES_EN  = 2'd3;

	typedef enum logic [2:0] {
		COIL_IDLE = 3'b001,
		COIL_ON   = 3'b010,
		COIL_REST = 3'b100
	} coil_state_t;

	typedef enum logic [3:0] {
		HM_OFF   = 4'b0001,
		HM_START = 4'b0010,
		HM_PULSE = 4'b0100,
		HM_PAUSE = 4'b1000
	} home_state_t;

	// Per-item commands broadcast to all reel channels
	typedef struct packed {
		logic        set_digit;
		logic        tick;
		logic        clear_all;
		logic        coil_on;
		logic        coil_off;
		logic        pos_clear;
		logic [15:0] pulse_len;
		logic [15:0] gap;
		logic [3:0]  digit;
	} reel_ctl_t;

	// Status returned by each reel channel
	typedef struct packed {
		logic on;
		logic drive;
		logic busy_next;
	} reel_stat_t;

endpackage

// ----- sv/srpd_reel.sv -----
// One reel channel: position, pulse queue and coil on/rest timer.
// Depends on srpd_pkg.
module srpd_reel (
	input  logic               clk,
	input  logic               arst_n,
	input  srpd_pkg::reel_ctl_t ctl,
	input  logic               sel,
	input  logic               open_sw,
	output srpd_pkg::reel_stat_t stat
);
	import srpd_pkg::*;

	logic [3:0]  pos_q, pos_n;
	logic [7:0]  pend_q, pend_n;
	logic [15:0] tmr_q, tmr_n;
	coil_state_t ph_q, ph_n;

	logic [4:0]  diff;
	logic [3:0]  steps;
	logic [8:0]  total;
	logic        start_pulse;
	coil_state_t ph_t;
	logic [15:0] tmr_t, tmr_d;
	logic        drive;

	always_comb begin
		// forward distance, mod 10
		diff = {1'b0, ctl.digit} - {1'b0, pos_q};
		steps = diff[4] ? 4'(diff + DIGIT_COUNT) : diff[3:0];
		total = {1'b0, pend_q} + {5'b0, steps};

		start_pulse = (ph_q == COIL_IDLE) && (pend_q != 8'd0);
		ph_t = start_pulse ? COIL_ON : ph_q;
		tmr_t = start_pulse ? ctl.pulse_len : tmr_q;
		tmr_d = (tmr_t != 16'd0) ? tmr_t - 16'd1 : tmr_t;

		pos_n = pos_q;
		pend_n = pend_q;
		tmr_n = tmr_q;
		ph_n = ph_q;
		drive = 1'b0;

		if (ctl.set_digit && sel) begin
			pend_n = total[8] ? QUEUE_MAX : total[7:0];
			pos_n = ctl.digit;
		end

		if (ctl.tick) begin
			if (start_pulse) begin
				pend_n = pend_q - 8'd1;
			end
			unique case (ph_t)
				COIL_ON: begin
					drive = 1'b1;
					if (tmr_d == 16'd0) begin
						tmr_n = ctl.gap;
						ph_n = (ctl.gap == 16'd0) ? COIL_IDLE : COIL_REST;
					end else begin
						tmr_n = tmr_d;
						ph_n = COIL_ON;
					end
				end
				COIL_REST: begin
					tmr_n = tmr_d;
					ph_n = (tmr_d == 16'd0) ? COIL_IDLE : COIL_REST;
				end
				default: begin
					tmr_n = tmr_t;
					ph_n = COIL_IDLE;
				end
			endcase
		end

		if (ctl.clear_all) begin
			pend_n = 8'd0;
			tmr_n = 16'd0;
			ph_n = COIL_IDLE;
		end
		// homing: coil_on then coil_off, so a one-tick pulse ends idle
		if (ctl.coil_on && open_sw) begin
			ph_n = COIL_ON;
		end
		if (ctl.coil_off) begin
			ph_n = COIL_IDLE;
		end
		if (ctl.pos_clear) begin
			pos_n = 4'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 4'd0;
			pend_q <= 8'd0;
			tmr_q <= 16'd0;
			ph_q <= COIL_IDLE;
		end else begin
			pos_q <= pos_n;
			pend_q <= pend_n;
			tmr_q <= tmr_n;
			ph_q <= ph_n;
		end
	end

	assign stat.on = (ph_q == COIL_ON);
	assign stat.drive = drive;
	assign stat.busy_next = (pend_n != 8'd0) || (ph_n != COIL_IDLE);

endmodule

// ----- sv/score_reel_pulse_driver_top.sv -----
// Score reel pulse driver: top level with input stage, homing sequencer
// and result register. Depends on srpd_pkg and srpd_reel.
//
// Usage:
//  - s_axis carries one request per beat: tuser is the kind (set digit,
//    time tick, start homing), tdata the reel address, digit and the zero
//    switch levels. m_axis returns exactly one result per request.
//  - cfg carries register writes (index, data); it is always ready and is
//    meant to be used only while the block is idle.
//  - A request moves from the input register into the result register,
//    which drives m_axis; an m_axis stall holds it back.
//  - Throughput: one request per cycle. All ten reel channels update in
//    parallel in a single pass from the input register to the result
//    register; the only loop is the per-reel timer, one step per tick.
//  - When m_axis stalls, the result register holds and the input register
//    takes one more request; s_axis_tready then drops until the result
//    is taken. Nothing is dropped or repeated.
//  - Reset clears all reel positions, queues and timers, stops homing and
//    loads the registers with pulse 50, gap 50, home pause 300, sets on.
module score_reel_pulse_driver_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [1:0] display_number, [4:2] reel_number, [8:5] digit_value,
	// [18:9] zero_switches, [23:19] zero
	input  logic [23:0] s_axis_tdata,
	// [1:0] opcode
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [9:0] coil_drive, [10] accepted, [11] homing_busy, [12] reels_idle,
	// [15:13] zero
	output logic [15:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import srpd_pkg::*;

	// configuration registers
	logic [15:0] pulse_ticks_q;
	logic [15:0] gap_ticks_q;
	logic [15:0] home_pause_q;
	logic        updates_en_q;

	// input stage
	logic                 in_valid_s1;
	logic [1:0]           opcode_s1;
	logic [1:0]           disp_s1;
	logic [2:0]           reel_s1;
	logic [3:0]           digit_s1;
	logic [NUM_REELS-1:0] zsw_s1;

	// homing sequencer
	home_state_t hm_q, hm_n;
	logic [3:0]  round_q, round_n;
	logic [15:0] htmr_q, htmr_n;

	// result register
	logic        out_valid_q;
	logic [15:0] out_data_q;

	logic                 adv;
	logic [15:0]          on_len;
	logic [NUM_REELS-1:0] sel, open_sw, on_bits, tick_bits, busy_bits;
	logic [NUM_REELS-1:0] drive;
	reel_ctl_t            ctl;
	reel_stat_t           stat [NUM_REELS];
	logic                 set_ok, accepted, end_rnd, idle;
	logic [15:0]          t_eff, t_dec, t_sat;
	logic [4:0]           round_inc;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_ticks_q <= 16'd50;
			gap_ticks_q <= 16'd50;
			home_pause_q <= 16'd300;
			updates_en_q <= 1'b1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_PULSE_TICKS: pulse_ticks_q <= cfg_data;
				REG_GAP_TICKS:   gap_ticks_q <= cfg_data;
				REG_HOME_PAUSE:  home_pause_q <= cfg_data;
				REG_UPDATES_EN:  updates_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// work the held request when the result slot is free or being emptied
	assign adv = in_valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !in_valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			in_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			opcode_s1 <= s_axis_tuser;
			disp_s1 <= s_axis_tdata[1:0];
			reel_s1 <= s_axis_tdata[4:2];
			digit_s1 <= s_axis_tdata[8:5];
			zsw_s1 <= s_axis_tdata[9 +: NUM_REELS];
		end
	end

	assign on_len = (pulse_ticks_q == 16'd0) ? 16'd1 : pulse_ticks_q;
	assign open_sw = ~zsw_s1;

	// reel channels; sel is one-hot on a valid address, zero otherwise
	for (genvar r = 0; r < NUM_REELS; r++) begin : g_reel
		assign sel[r] = (disp_s1 == 2'(r / REELS_PER_DISPLAY + 1))
			&& (reel_s1 == 3'(r % REELS_PER_DISPLAY + 1));
		srpd_reel u_reel (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.sel     (sel[r]),
			.open_sw (open_sw[r]),
			.stat    (stat[r])
		);
		assign on_bits[r] = stat[r].on;
		assign tick_bits[r] = stat[r].drive;
		assign busy_bits[r] = stat[r].busy_next;
	end

	assign set_ok = updates_en_q && (hm_q == HM_OFF) && (digit_s1 <= DIGIT_MAX) && (|sel);

	// shared countdown for the homing pulse and pause
	assign t_eff = (hm_q == HM_START) ? on_len : htmr_q;
	assign t_dec = t_eff - 16'd1;
	assign t_sat = (htmr_q != 16'd0) ? htmr_q - 16'd1 : htmr_q;
	assign round_inc = {1'b0, round_q} + 5'd1;

	always_comb begin
		hm_n = hm_q;
		round_n = round_q;
		htmr_n = htmr_q;
		ctl = '0;
		ctl.pulse_len = on_len;
		ctl.gap = gap_ticks_q;
		ctl.digit = digit_s1;
		accepted = 1'b0;
		end_rnd = 1'b0;
		drive = on_bits;

		if (adv) begin
			case (opcode_s1)
				OP_SET: begin
					if (set_ok) begin
						ctl.set_digit = 1'b1;
						accepted = 1'b1;
					end
				end
				OP_TICK: begin
					unique case (hm_q)
						HM_OFF: begin
							ctl.tick = 1'b1;
							drive = tick_bits;
						end
						HM_START, HM_PULSE: begin
							if (hm_q == HM_START && open_sw == '0) begin
								// all reels at zero: round ends at once
								end_rnd = 1'b1;
								drive = '0;
							end else begin
								if (hm_q == HM_START) begin
									ctl.coil_on = 1'b1;
									drive = open_sw | on_bits;
								end
								if (t_dec == 16'd0) begin
									ctl.coil_off = 1'b1;
									if (home_pause_q != 16'd0) begin
										hm_n = HM_PAUSE;
										htmr_n = home_pause_q;
									end else begin
										end_rnd = 1'b1;
									end
								end else begin
									hm_n = HM_PULSE;
									htmr_n = t_dec;
								end
							end
						end
						HM_PAUSE: begin
							htmr_n = t_sat;
							if (t_sat == 16'd0) begin
								end_rnd = 1'b1;
							end
						end
						default: hm_n = HM_OFF;
					endcase
				end
				OP_HOME: begin
					if (hm_q == HM_OFF) begin
						ctl.clear_all = 1'b1;
						round_n = 4'd0;
						htmr_n = 16'd0;
						hm_n = HM_START;
						accepted = 1'b1;
						drive = '0;
					end
				end
				default: ;
			endcase
		end

		if (end_rnd) begin
			if (round_inc >= 5'(HOME_ROUNDS)) begin
				ctl.pos_clear = 1'b1;
				round_n = 4'd0;
				hm_n = HM_OFF;
			end else begin
				round_n = round_inc[3:0];
				hm_n = HM_START;
			end
		end
	end

	assign idle = (hm_n == HM_OFF) && (busy_bits == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hm_q <= HM_OFF;
			round_q <= 4'd0;
			htmr_q <= 16'd0;
		end else begin
			hm_q <= hm_n;
			round_q <= round_n;
			htmr_q <= htmr_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= {3'b000, idle, (hm_n != HM_OFF), accepted, drive};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;

endmodule

// ----- sim/score_reel_pulse_driver_checker.sv -----
`timescale 1ns / 1ps
// Bus monitor, reel bank predictor and result comparator for score_reel_pulse_driver_top.
// Depends on srpd_pkg for item kinds, register indexes and state encodings.
module score_reel_pulse_driver_checker
	import srpd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic        req_ready,
	input  logic [23:0] req_data,
	input  logic [1:0]  req_kind,
	input  logic        res_valid,
	input  logic        res_ready,
	input  logic [15:0] res_data,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          mismatches,
	output int          outstanding
);

	logic [15:0] pulse_len_reg;
	logic [15:0] gap_reg;
	logic [15:0] home_pause_reg;
	logic        sets_enabled;

	logic [3:0]  reel_pos [NUM_REELS];
	logic [7:0]  queued [NUM_REELS];
	logic [15:0] phase_cnt [NUM_REELS];
	coil_state_t coil [NUM_REELS];
	home_state_t home_st;
	logic [3:0]  home_rnd;
	logic [15:0] home_cnt;

	logic [15:0] predicted_results [$];
	int          results_seen = 0;

	initial mismatches = 0;
	initial outstanding = 0;

	function automatic logic [9:0] coils_on();
		logic [9:0] bits;
		bits = '0;
		for (int r = 0; r < NUM_REELS; r++)
			if (coil[r] == COIL_ON)
				bits[r] = 1'b1;
		return bits;
	endfunction

	task automatic clear_channels();
		for (int r = 0; r < NUM_REELS; r++) begin
			queued[r] = '0;
			phase_cnt[r] = '0;
			coil[r] = COIL_IDLE;
		end
	endtask

	task automatic clear_positions();
		for (int r = 0; r < NUM_REELS; r++)
			reel_pos[r] = '0;
	endtask

	task automatic finish_round();
		home_rnd = home_rnd + 4'd1;
		if (int'(home_rnd) >= HOME_ROUNDS) begin
			clear_positions();
			home_rnd = '0;
			home_st = HM_OFF;
		end else begin
			home_st = HM_START;
		end
	endtask

	// Works one request against the reel bank and returns the packed result.
	task automatic step_reel_bank(input logic [1:0] kind, input logic [23:0] fields,
			output logic [15:0] result);
		logic [1:0]  disp;
		logic [2:0]  reel;
		logic [3:0]  digit;
		logic [9:0]  zsw;
		logic [9:0]  drive;
		logic [15:0] on_len;
		logic        took;
		logic        idle;
		int          idx;
		int          steps;
		int          total;
		disp = fields[1:0];
		reel = fields[4:2];
		digit = fields[8:5];
		zsw = fields[18:9];
		drive = '0;
		took = 1'b0;
		on_len = (pulse_len_reg == 16'd0) ? 16'd1 : pulse_len_reg;
		case (kind)
			OP_SET: begin
				if (sets_enabled && home_st == HM_OFF && digit <= DIGIT_MAX
						&& disp >= 2'd1 && int'(disp) <= NUM_DISPLAYS
						&& reel >= 3'd1 && int'(reel) <= REELS_PER_DISPLAY) begin
					idx = (int'(disp) - 1) * REELS_PER_DISPLAY + int'(reel) - 1;
					steps = (int'(digit) + int'(DIGIT_COUNT) - int'(reel_pos[idx]))
						% int'(DIGIT_COUNT);
					total = int'(queued[idx]) + steps;
					queued[idx] = (total > int'(QUEUE_MAX)) ? QUEUE_MAX : 8'(total);
					reel_pos[idx] = digit;
					took = 1'b1;
				end
				drive = coils_on();
			end
			OP_TICK: begin
				if (home_st != HM_OFF) begin
					if (home_st == HM_START) begin
						if (zsw == 10'h3FF) begin
							finish_round();
						end else begin
							for (int r = 0; r < NUM_REELS; r++)
								if (!zsw[r])
									coil[r] = COIL_ON;
							home_cnt = on_len;
							home_st = HM_PULSE;
						end
					end
					if (home_st == HM_PULSE) begin
						drive = coils_on();
						home_cnt = home_cnt - 16'd1;
						if (home_cnt == 16'd0) begin
							for (int r = 0; r < NUM_REELS; r++)
								coil[r] = COIL_IDLE;
							if (home_pause_reg != 16'd0) begin
								home_st = HM_PAUSE;
								home_cnt = home_pause_reg;
							end else begin
								finish_round();
							end
						end
					end else if (home_st == HM_PAUSE) begin
						if (home_cnt != 16'd0)
							home_cnt = home_cnt - 16'd1;
						if (home_cnt == 16'd0)
							finish_round();
					end
				end else begin
					for (int r = 0; r < NUM_REELS; r++) begin
						if (coil[r] == COIL_IDLE && queued[r] != 8'd0) begin
							queued[r] = queued[r] - 8'd1;
							coil[r] = COIL_ON;
							phase_cnt[r] = on_len;
						end
						if (coil[r] == COIL_ON) begin
							drive[r] = 1'b1;
							if (phase_cnt[r] != 16'd0)
								phase_cnt[r] = phase_cnt[r] - 16'd1;
							if (phase_cnt[r] == 16'd0) begin
								phase_cnt[r] = gap_reg;
								coil[r] = (gap_reg == 16'd0) ? COIL_IDLE : COIL_REST;
							end
						end else if (coil[r] == COIL_REST) begin
							if (phase_cnt[r] != 16'd0)
								phase_cnt[r] = phase_cnt[r] - 16'd1;
							if (phase_cnt[r] == 16'd0)
								coil[r] = COIL_IDLE;
						end
					end
				end
			end
			OP_HOME: begin
				if (home_st == HM_OFF) begin
					clear_channels();
					home_rnd = '0;
					home_cnt = '0;
					home_st = HM_START;
					took = 1'b1;
				end
				drive = coils_on();
			end
			default: drive = coils_on();
		endcase
		idle = (home_st == HM_OFF);
		for (int r = 0; r < NUM_REELS; r++)
			if (queued[r] != 8'd0 || coil[r] != COIL_IDLE)
				idle = 1'b0;
		result = {3'b000, idle, home_st != HM_OFF, took, drive};
	endtask

	task automatic log_mismatch(input string field, input logic [15:0] got,
			input logic [15:0] want);
		$display("[%0t] result %0d: %s is %h, predicted %h", $time, results_seen,
			field, got, want);
		mismatches = mismatches + 1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic [15:0] want;
		if (!arst_n) begin
			pulse_len_reg = 16'd50;
			gap_reg = 16'd50;
			home_pause_reg = 16'd300;
			sets_enabled = 1'b1;
			clear_positions();
			clear_channels();
			home_st = HM_OFF;
			home_rnd = '0;
			home_cnt = '0;
			predicted_results.delete();
			outstanding = 0;
		end else begin
			// Results first: one accepted at this edge belongs to an older request.
			if (res_valid && res_ready) begin
				if (predicted_results.size() == 0) begin
					log_mismatch("result with no request", res_data, 16'h0000);
				end else begin
					want = predicted_results.pop_front();
					if (res_data[9:0] !== want[9:0])
						log_mismatch("coil_drive", 16'(res_data[9:0]), 16'(want[9:0]));
					if (res_data[10] !== want[10])
						log_mismatch("accepted", 16'(res_data[10]), 16'(want[10]));
					if (res_data[11] !== want[11])
						log_mismatch("homing_busy", 16'(res_data[11]), 16'(want[11]));
					if (res_data[12] !== want[12])
						log_mismatch("reels_idle", 16'(res_data[12]), 16'(want[12]));
					if (res_data[15:13] !== want[15:13])
						log_mismatch("pad bits", 16'(res_data[15:13]), 16'(want[15:13]));
				end
				results_seen = results_seen + 1;
			end
			if (req_valid && req_ready) begin
				step_reel_bank(req_kind, req_data, want);
				predicted_results.push_back(want);
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_PULSE_TICKS: pulse_len_reg = cfg_data;
					REG_GAP_TICKS:   gap_reg = cfg_data;
					REG_HOME_PAUSE:  home_pause_reg = cfg_data;
					REG_UPDATES_EN:  sets_enabled = cfg_data[0];
					default: ;
				endcase
			end
			outstanding = predicted_results.size();
		end
	end

endmodule

// ----- sim/score_reel_pulse_driver_top_tb.sv -----
`timescale 1ns / 1ps
// Testbench top for score_reel_pulse_driver_top: clock, reset, request and
// register stimulus, verdict. Depends on srpd_pkg and score_reel_pulse_driver_checker.
module score_reel_pulse_driver_top_tb;
	import srpd_pkg::*;

	// Kind code the block does not define; it must be answered and do nothing.
	localparam logic [1:0] OP_UNUSED = 2'd3;
	// Generous: ~700 requests with sender gaps and receiver stalls, plus drains.
	localparam int CYCLE_LIMIT = 300000;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	int mismatches;
	int outstanding;
	int sent = 0;          // requests accepted so far
	int idle_pct = 0;      // chance per slot that a sender gap or receiver stall starts
	int stall_left = 0;
	int cycle_count = 0;

	// Register values last written, used only to size the homing sequences.
	logic [15:0] pulse_cfg = 16'd50;
	logic [15:0] pause_cfg = 16'd300;

	score_reel_pulse_driver_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	score_reel_pulse_driver_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (s_axis_tvalid),
		.req_ready   (s_axis_tready),
		.req_data    (s_axis_tdata),
		.req_kind    (s_axis_tuser),
		.res_valid   (m_axis_tvalid),
		.res_ready   (m_axis_tready),
		.res_data    (m_axis_tdata),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a hung handshake or a lost result ends the run here.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("** score_reel_pulse_driver_top: FAILED **");
		$finish;
	end

	// Result side back-pressure: stall bursts started at random by idle_pct.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			m_axis_tready = 1'b0;
			stall_left--;
		end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			m_axis_tready = 1'b0;
			stall_left = $urandom_range(0, 15);
		end else begin
			m_axis_tready = 1'b1;
		end
	end

	// tdata layout: display, reel, digit, zero switches, zero pad.
	function automatic logic [23:0] req_fields(logic [1:0] disp, logic [2:0] reel,
			logic [3:0] digit, logic [9:0] zsw);
		return {5'b00000, zsw, digit, reel, disp};
	endfunction

	// One request; valid stays high afterwards so back-to-back requests never
	// see valid drop and rise in the same step. Callers that pause lower it.
	task automatic push_request(input logic [1:0] kind, input logic [23:0] fields);
		int gap;
		if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			gap = $urandom_range(1, 16);
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tuser = kind;
		s_axis_tdata = fields;
		s_axis_tvalid = 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		sent++;
	endtask

	// Fields a kind does not read still carry random bits.
	task automatic send_set(input logic [1:0] disp, input logic [2:0] reel,
			input logic [3:0] digit);
		push_request(OP_SET, req_fields(disp, reel, digit, 10'($urandom)));
	endtask

	task automatic send_tick(input logic [9:0] zsw);
		push_request(OP_TICK, req_fields(2'($urandom), 3'($urandom), 4'($urandom), zsw));
	endtask

	task automatic send_home();
		push_request(OP_HOME, req_fields(2'($urandom), 3'($urandom), 4'($urandom),
			10'($urandom)));
	endtask

	// Drop valid, let every result drain, then let the pipeline settle.
	task automatic wait_quiet();
		s_axis_tvalid = 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] index, input logic [15:0] value);
		cfg_index = index;
		cfg_data = value;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic apply_settings(input logic [15:0] pulse, input logic [15:0] gap,
			input logic [15:0] pause, input logic en);
		wait_quiet();
		write_reg(REG_PULSE_TICKS, pulse);
		write_reg(REG_GAP_TICKS, gap);
		write_reg(REG_HOME_PAUSE, pause);
		// only bit 0 counts; the rest is random
		write_reg(REG_UPDATES_EN, {15'($urandom), en});
		pulse_cfg = pulse;
		pause_cfg = pause;
	endtask

	// Homing request followed by enough ticks for all rounds to end. When the
	// settings make rounds long, the switches read closed so rounds take one tick.
	task automatic run_homing();
		int ticks;
		bit closed_only;
		logic [9:0] zsw;
		ticks = HOME_ROUNDS * ((pulse_cfg == 16'd0 ? 1 : int'(pulse_cfg))
			+ int'(pause_cfg) + 1) + 2;
		closed_only = (ticks > 200);
		if (closed_only)
			ticks = HOME_ROUNDS + 2;
		send_home();
		for (int i = 0; i < ticks; i++) begin
			// ignored traffic during homing: sets and repeated homing requests
			if ($urandom_range(0, 9) == 0) begin
				if ($urandom_range(0, 1) == 0)
					send_set(2'($urandom_range(1, 2)), 3'($urandom_range(1, 5)),
						4'($urandom_range(0, 9)));
				else
					send_home();
			end
			case ($urandom_range(0, 4))
				0: zsw = 10'($urandom);
				1: zsw = 10'($urandom | $urandom);
				2: zsw = 10'($urandom | $urandom | $urandom);
				3: zsw = '0;
				default: zsw = '1;
			endcase
			send_tick(closed_only ? 10'h3FF : zsw);
		end
	endtask

	// A few digit updates, mostly well-addressed, then a run of ticks.
	task automatic run_burst();
		int n;
		n = $urandom_range(1, 6);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 7) == 0)
				send_set(2'($urandom), 3'($urandom), 4'($urandom));
			else
				send_set(2'($urandom_range(1, 2)), 3'($urandom_range(1, 5)),
					($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'($urandom_range(0, 9)));
		end
		n = $urandom_range(1, 40);
		for (int i = 0; i < n; i++)
			send_tick(10'($urandom));
	endtask

	// Stepping one reel down one digit at a time queues nine pulses per
	// request, so thirty of them push the queue into saturation when updates are enabled.
	task automatic run_fill();
		logic [1:0] disp;
		logic [2:0] reel;
		disp = 2'($urandom_range(1, 2));
		reel = 3'($urandom_range(1, 5));
		for (int i = 0; i < 30; i++)
			send_set(disp, reel, 4'(9 - (i % 10)));
		for (int i = 0; i < 4; i++)
			send_tick(10'($urandom));
	endtask

	task automatic run_noise();
		int n;
		n = $urandom_range(1, 5);
		for (int i = 0; i < n; i++)
			push_request(2'($urandom), req_fields(2'($urandom), 3'($urandom),
				4'($urandom), 10'($urandom)));
	endtask

	task automatic random_phase(input logic [15:0] pulse, input logic [15:0] gap,
			input logic [15:0] pause, input logic en, input int pct, input int count);
		int target;
		int pick;
		apply_settings(pulse, gap, pause, en);
		idle_pct = pct;
		target = sent + count;
		while (sent < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 50)
				run_burst();
			else if (pick < 75)
				run_homing();
			else if (pick < 82)
				run_fill();
			else
				run_noise();
		end
	endtask

	initial begin
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed, reset settings: a wrap-around move, zero move, blanks,
		// out-of-range addresses, the undefined kind, a few ticks.
		send_set(2'd1, 3'd1, 4'd9);
		send_set(2'd1, 3'd1, 4'd8);
		send_set(2'd2, 3'd5, 4'd0);
		send_set(2'd2, 3'd5, 4'd15);
		send_set(2'd0, 3'd1, 4'd3);
		send_set(2'd3, 3'd2, 4'd3);
		send_set(2'd1, 3'd0, 4'd3);
		send_set(2'd1, 3'd7, 4'd3);
		send_set(2'd2, 3'd6, 4'd3);
		push_request(OP_UNUSED, req_fields(2'd1, 3'd1, 4'd5, 10'h3FF));
		send_tick(10'h000);
		send_tick(10'h3FF);

		// Directed, zero pulse length / gap / pause: homing, ignored second
		// homing request and set while homing, ten one-tick rounds.
		apply_settings(16'd0, 16'd0, 16'd0, 1'b1);
		send_home();
		send_home();
		send_set(2'd1, 3'd2, 4'd5);
		send_tick(10'h000);
		send_tick(10'h3FF);
		send_tick(10'h2AA);
		send_tick(10'h155);
		send_tick(10'h000);
		send_tick(10'h3FF);
		send_tick(10'h001);
		send_tick(10'h200);
		send_tick(10'h3FE);
		send_tick(10'h000);
		send_set(2'd1, 3'd5, 4'd4);

		// Random phases across settings, extremes among them. Each phase
		// overruns its count by the tail of its last sequence.
		random_phase(16'd1, 16'd0, 16'd0, 1'b1, 20, 70);
		random_phase(16'd3, 16'd2, 16'd4, 1'b1, 0, 60);
		random_phase(16'd2, 16'd1, 16'd1, 1'b0, 25, 45);
		random_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 20, 45);
		random_phase(16'($urandom), 16'($urandom), 16'($urandom), 1'b1, 20, 45);
		random_phase(16'($urandom_range(0, 4)), 16'($urandom_range(0, 3)),
			16'($urandom_range(0, 5)), 1'b1, 30, 90);
		random_phase(16'd1, 16'd3, 16'd2, 1'b1, 15, 75);
		// last stretch runs with no idling on either side
		random_phase(16'd2, 16'd1, 16'd2, 1'b1, 0, 80);

		wait_quiet();
		if (mismatches == 0)
			$display("** score_reel_pulse_driver_top: PASSED **");
		else
			$display("** score_reel_pulse_driver_top: FAILED **");
		$finish;
	end

endmodule

// ----- sim.f -----
sv/srpd_pkg.sv
sv/srpd_reel.sv
sv/score_reel_pulse_driver_top.sv
sim/score_reel_pulse_driver_checker.sv
sim/score_reel_pulse_driver_top_tb.sv
